// ----- rtl/vrp_pkg.sv -----
// Package for the vertex rotate/project core: widths, register indexes, sine table.
// Depends on nothing. Used by vrp_sin_rom, vrp_divider and vertex_rotate_project_core.
`default_nettype none
package vrp_pkg;
  localparam int ANGLE_BITS_DEF = 10;
  localparam int COORD_FRAC_DEF = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_Y = 3'd0,
    REG_CENTER_Z = 3'd1,
    REG_Z_SHIFT  = 3'd2,
    REG_ROW_X    = 3'd3,
    REG_ROW_Y    = 3'd4,
    REG_ROW_Z    = 3'd5,
    REG_ROW_W    = 3'd6
  } cfg_reg_e;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  // Quarter-wave sine in Q1.14 for step k of qsteps; evaluated at elaboration only.
  function automatic logic [14:0] sin_quarter(input int unsigned k, input int unsigned qsteps);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    begin
      x = (64'(k) * PI_HALF_Q30) / 64'(qsteps);
      x2 = (x * x) >> 30;
      t = ONE_Q30 - x2 / 64'd72;
      t = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      s = (x * t) >> 30;
      r = (s + 64'd32768) >> 16;
      if (r > 64'd16384) r = 64'd16384;
      sin_quarter = r[14:0];
    end
  endfunction
endpackage
`default_nettype wire

// ----- rtl/vrp_sin_rom.sv -----
// Sine lookup for one phase: quarter-wave table plus quadrant folding, Q1.14 out.
// Depends on vrp_pkg.
`default_nettype none
module vrp_sin_rom #(
  parameter int ANGLE_BITS = vrp_pkg::ANGLE_BITS_DEF
) (
  input  wire logic [ANGLE_BITS-1:0] phase_i,
  output logic signed [15:0]         sin_o
);
  import vrp_pkg::*;
  localparam int QBITS = ANGLE_BITS - 2;
  localparam int QSTEPS = 1 << QBITS;

  logic [14:0] tbl [QSTEPS+1];
  for (genvar k = 0; k <= QSTEPS; k++) begin : g_tbl
    assign tbl[k] = sin_quarter(k, QSTEPS);
  end

  logic [1:0] quad;
  logic [QBITS-1:0] res;
  logic [QBITS:0] idx;
  logic [14:0] mag;
  always_comb begin
    quad = phase_i[ANGLE_BITS-1 -: 2];
    res = phase_i[QBITS-1:0];
    idx = quad[0] ? ((QBITS+1)'(QSTEPS) - {1'b0, res}) : {1'b0, res};
    mag = tbl[idx];
    sin_o = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end
endmodule
`default_nettype wire

// ----- rtl/vrp_divider.sv -----
// Pipelined signed fixed-point divider: one quotient bit per stage, saturating to 32 bits.
// Depends on vrp_pkg. Accepts one division per cycle.
`default_nettype none
module vrp_divider #(
  parameter int NW = 64,
  parameter int DW = 64,
  parameter int COORD_FRAC = vrp_pkg::COORD_FRAC_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire logic signed [NW-1:0] num_i,
  input  wire logic signed [DW-1:0] den_i,
  output logic signed [31:0]        quot_o
);
  import vrp_pkg::*;
  // Quotient bits kept: 33 integer bits (anything >= 2^32 saturates) plus fraction.
  localparam int QB = 33 + COORD_FRAC;
  localparam int RW = DW + 1;

  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [NW-1:0] n;
    logic [RW-1:0] d;
    logic [RW-1:0] r;
    logic [QB-1:0] q;
  } dstage_t;

  dstage_t st_q [QB+1];
  logic    v_q [QB+1];

  // Stage 0 takes magnitudes; shifted numerator feeds the remainder one bit per stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else v_q[0] <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    st_q[0].neg <= num_i[NW-1] ^ den_i[DW-1];
    st_q[0].ovf <= 1'b0;
    st_q[0].n <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    st_q[0].d <= den_i[DW-1] ? RW'(-{den_i[DW-1], den_i}) : RW'({1'b0, den_i});
    st_q[0].r <= '0;
    st_q[0].q <= '0;
  end

  // Dividend is |n| * 2^COORD_FRAC; bits above the quotient range are prescanned into r.
  for (genvar s = 0; s < QB; s++) begin : g_st
    localparam int BI = QB - 1 - s - COORD_FRAC; // numerator bit entering, <0 means zero
    logic [RW:0] rs;
    logic [RW:0] df;
    logic        bin;
    dstage_t     nx;
    always_comb begin
      nx = st_q[s];
      if (s == 0) begin
        // Bits of |n| above position 32 start the remainder directly.
        nx.r = '0;
        for (int i = NW - 1; i > 32; i--) nx.r = RW'({nx.r, st_q[s].n[i]});
        // A prescanned part not below d means an integer quotient of 2^33 or more.
        nx.ovf = (nx.r >= st_q[s].d);
      end
      bin = (BI >= 0 && BI < NW) ? st_q[s].n[(BI >= 0 && BI < NW) ? BI : 0] : 1'b0;
      rs = {nx.r, bin};
      df = rs - {1'b0, st_q[s].d};
      if (!df[RW]) begin
        nx.r = df[RW-1:0];
        nx.q = {st_q[s].q[QB-2:0], 1'b1};
      end else begin
        nx.r = rs[RW-1:0];
        nx.q = {st_q[s].q[QB-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[s+1] <= 1'b0;
      else v_q[s+1] <= v_q[s];
    end
    always_ff @(posedge clk_i) st_q[s+1] <= nx;
  end

  logic [QB-1:0] qf;
  logic signed [33:0] qs;
  logic sat_hi;
  always_comb begin
    qf = st_q[QB].q;
    // Integer part >= 2^32 or fixed result > 2^31 saturates by sign.
    sat_hi = st_q[QB].ovf || (qf > QB'(64'd1 << 31));
    if (sat_hi) qs = st_q[QB].neg ? -34'sd2147483648 : 34'sd2147483647;
    else qs = st_q[QB].neg ? -$signed({1'b0, qf[32:0]}) : $signed({1'b0, qf[32:0]});
  end
  always_ff @(posedge clk_i) begin
    if (v_q[QB]) quot_o <= (qs > 34'sd2147483647) ? 32'sh7fffffff : qs[31:0];
  end
endmodule
`default_nettype wire

// ----- rtl/vertex_rotate_project_core.sv -----
// Rotates a vertex about X around a set centre, adds a z shift, applies a 4x4 Q4.12
// matrix and divides by w, or passes the rounded row sums with no_divide_o when w
// is zero. One vertex accepted every cycle, busy is always low. The receiver cannot
// stall: each result shows for one cycle with done_o.
// Reset (async, low) clears valid bits and loads the register defaults.
`default_nettype none
module vertex_rotate_project_core #(
  parameter int ANGLE_BITS = vrp_pkg::ANGLE_BITS_DEF,
  parameter int COORD_FRAC = vrp_pkg::COORD_FRAC_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [vrp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [vrp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic signed [31:0]             in_x_i,
  input  wire logic signed [31:0]             in_y_i,
  input  wire logic signed [31:0]             in_z_i,
  input  wire logic [9:0]                     angle_i,
  output logic                                done_o,
  output logic signed [31:0]                  out_x_o,
  output logic signed [31:0]                  out_y_o,
  output logic signed [31:0]                  out_z_o,
  output logic                                no_divide_o
);
  import vrp_pkg::*;
  localparam int QB = 33 + COORD_FRAC;
  localparam int DLAT = QB + 2;
  localparam int ABITS = (ANGLE_BITS < 10) ? ANGLE_BITS : 10;

  logic signed [31:0] cy_q, cz_q, zs_q;
  logic [63:0] rx_q, ry_q, rz_q, rw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cy_q <= '0;
      cz_q <= '0;
      zs_q <= 32'sd176947;
      rx_q <= 64'd4096;
      ry_q <= 64'h10000000;
      rz_q <= 64'h100000000000;
      rw_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTER_Y: cy_q <= cfg_data_i[31:0];
        REG_CENTER_Z: cz_q <= cfg_data_i[31:0];
        REG_Z_SHIFT:  zs_q <= cfg_data_i[31:0];
        REG_ROW_X:    rx_q <= cfg_data_i;
        REG_ROW_Y:    ry_q <= cfg_data_i;
        REG_ROW_Z:    rz_q <= cfg_data_i;
        REG_ROW_W:    rw_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic acc;
  assign acc = start;

  // Stage 1: sine/cosine lookup.
  logic [ANGLE_BITS-1:0] ph, phc;
  logic signed [15:0] sb, sa;
  assign ph = ANGLE_BITS'(angle_i[ABITS-1:0]);
  assign phc = ph + ANGLE_BITS'(1 << (ANGLE_BITS - 2));
  vrp_sin_rom #(.ANGLE_BITS(ANGLE_BITS)) u_sin (.phase_i(ph), .sin_o(sb));
  vrp_sin_rom #(.ANGLE_BITS(ANGLE_BITS)) u_cos (.phase_i(phc), .sin_o(sa));

  logic [7:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else v_q <= {v_q[6:0], acc};
  end

  logic signed [31:0] x1_q, y1_q, z1_q;
  logic signed [15:0] a1_q, b1_q;
  always_ff @(posedge clk_i) begin
    x1_q <= in_x_i; y1_q <= in_y_i; z1_q <= in_z_i;
    a1_q <= sa; b1_q <= sb;
  end

  // Stage 2: rotation products.
  logic signed [47:0] p_ay_q, p_bz_q, p_by_q, p_az_q, p_acy_q, p_bcz_q, p_bcy_q, p_acz_q;
  logic signed [31:0] x2_q;
  logic signed [16:0] oma;
  assign oma = 17'sd16384 - 17'(a1_q);
  always_ff @(posedge clk_i) begin
    x2_q <= x1_q;
    p_ay_q <= a1_q * y1_q;
    p_bz_q <= b1_q * z1_q;
    p_by_q <= b1_q * y1_q;
    p_az_q <= a1_q * z1_q;
    p_acy_q <= 48'(oma) * 48'(cy_q);
    p_bcz_q <= b1_q * cz_q;
    p_bcy_q <= b1_q * cy_q;
    p_acz_q <= 48'(oma) * 48'(cz_q);
  end

  // Stage 3: rotation sums, rounded to Q16.16.
  logic signed [50:0] sy, sz;
  logic signed [37:0] yr3_q, zr3_q;
  logic signed [31:0] x3_q;
  always_comb begin
    sy = 51'(p_ay_q) - 51'(p_bz_q) + 51'(p_acy_q) + 51'(p_bcz_q) + 51'sd8192;
    sz = 51'(p_by_q) + 51'(p_az_q) - 51'(p_bcy_q) + 51'(p_acz_q) + 51'sd8192;
  end
  always_ff @(posedge clk_i) begin
    x3_q <= x2_q;
    yr3_q <= 38'(sy >>> 14);
    zr3_q <= 38'(sz >>> 14) + 38'(zs_q);
  end

  // Stage 4: matrix products.
  logic signed [53:0] m_q [4][3];
  logic signed [15:0] k_q [4];
  logic [63:0] rows [4];
  assign rows[0] = rx_q; assign rows[1] = ry_q; assign rows[2] = rz_q; assign rows[3] = rw_q;
  for (genvar r = 0; r < 4; r++) begin : g_row
    always_ff @(posedge clk_i) begin
      m_q[r][0] <= 54'($signed(rows[r][15:0])) * 54'(x3_q);
      m_q[r][1] <= 54'($signed(rows[r][31:16])) * 54'(yr3_q);
      m_q[r][2] <= 54'($signed(rows[r][47:32])) * 54'(zr3_q);
      k_q[r] <= (r == 3) ? 16'sd0 : $signed(rows[r][63:48]);
    end
  end

  // Stage 5: row sums.
  logic signed [57:0] t_q [4];
  for (genvar r = 0; r < 4; r++) begin : g_sum
    always_ff @(posedge clk_i) begin
      t_q[r] <= 58'(m_q[r][0]) + 58'(m_q[r][1]) + 58'(m_q[r][2])
              + (58'(k_q[r]) <<< COORD_FRAC);
    end
  end

  // Stage 6: zero-w path and divider launch.
  logic nd6_q;
  logic signed [31:0] rnd6_q [3];
  function automatic logic signed [31:0] rsat(input logic signed [57:0] v);
    logic signed [57:0] s;
    begin
      s = (v + 58'sd2048) >>> 12;
      if (s > 58'sd2147483647) rsat = 32'sh7fffffff;
      else if (s < -58'sd2147483648) rsat = 32'sh80000000;
      else rsat = s[31:0];
    end
  endfunction
  always_ff @(posedge clk_i) begin
    nd6_q <= (t_q[3] == '0);
    for (int i = 0; i < 3; i++) rnd6_q[i] <= rsat(t_q[i]);
  end

  // The divider samples the row sums, so its valid travels with t_q.
  logic signed [31:0] qo [3];
  for (genvar i = 0; i < 3; i++) begin : g_div
    vrp_divider #(.NW(58), .DW(58), .COORD_FRAC(COORD_FRAC)) u_div (
      .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(v_q[4]),
      .num_i(t_q[i]), .den_i(t_q[3]), .quot_o(qo[i])
    );
  end

  // Delay the zero-w results to meet the divider outputs.
  logic [DLAT-1:0] dv_q;
  logic            dnd_q [DLAT];
  logic signed [31:0] dr_q [DLAT][3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q <= '0;
    else dv_q <= {dv_q[DLAT-2:0], v_q[5]};
  end
  always_ff @(posedge clk_i) begin
    dnd_q[0] <= nd6_q;
    dr_q[0] <= rnd6_q;
    for (int s = 1; s < DLAT; s++) begin
      dnd_q[s] <= dnd_q[s-1];
      dr_q[s] <= dr_q[s-1];
    end
  end

  // dv_q[0] aligns with dnd_q[0]; tap DLAT-2 lines up with the divider output quot_o.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= dv_q[DLAT-2];
  end
  always_ff @(posedge clk_i) begin
    no_divide_o <= dnd_q[DLAT-2];
    out_x_o <= dnd_q[DLAT-2] ? dr_q[DLAT-2][0] : qo[0];
    out_y_o <= dnd_q[DLAT-2] ? dr_q[DLAT-2][1] : qo[1];
    out_z_o <= dnd_q[DLAT-2] ? dr_q[DLAT-2][2] : qo[2];
  end
endmodule
`default_nettype wire
